/* design/ir_beam_interval_monitor_unit_assert.svh */
// Assertion macros shared by the checker of the beam interval monitor.
`ifndef IR_BEAM_INTERVAL_MONITOR_UNIT_ASSERT_SVH
`define IR_BEAM_INTERVAL_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define IBIM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibim check failed");

// Next-cycle implication, switched off while reset is held.
`define IBIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibim check failed");

`endif

/* design/ibim_pkg.sv */
`timescale 1ns / 1ps

package ibim_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int CHAN_W     = 3;
    localparam int WIN_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int HOLDOFF_W  = 16;

    // Holdoff timer load at reset; a written holdoff value is ignored, and only a
    // reset loads the timer, always with this same value.
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW      = 3'd0,
        CFG_WINDOW_HIGH     = 3'd1,
        CFG_TICKS_PER_MS    = 3'd2,
        CFG_MS_PER_CHECK    = 3'd3,
        CFG_DETECT_PULSE_MS = 3'd4,
        CFG_ALARM_MS        = 3'd5,
        CFG_HOLDOFF_MS      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [WIN_W-1:0] window_low;
        logic [WIN_W-1:0] window_high;
        logic [7:0]       ticks_per_ms;
        logic [9:0]       ms_per_check;
        logic [7:0]       detect_pulse_ms;
        logic [7:0]       alarm_ms;
    } ibim_cfg_t;

    localparam ibim_cfg_t CFG_RESET = '{
        window_low:      16'd20,
        window_high:     16'd28,
        ticks_per_ms:    8'd20,
        ms_per_check:    10'd1000,
        detect_pulse_ms: 8'd25,
        alarm_ms:        8'd100
    };

    typedef struct packed {
        logic tick;
        logic edge_hit;
    } ibim_ctrl_t;

    typedef struct packed {
        logic detect;
        logic alarm;
        logic fault;
        logic bad;
    } ibim_status_t;

endpackage

/* design/ibim_lane.sv */
`timescale 1ns / 1ps

module ibim_lane #(
    parameter int COUNT_WIDTH = ibim_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick,
    input  logic                   clear,
    output logic [COUNT_WIDTH-1:0] count,
    output logic [COUNT_WIDTH-1:0] last
);
    import ibim_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] last_reg;
    logic [COUNT_WIDTH-1:0] last_next;

    always_comb
    begin
        count_next = count_reg;
        last_next  = last_reg;
        if (tick && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else if (clear)
        begin
            last_next  = count_reg;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    assign count = count_reg;
    assign last  = last_reg;

endmodule

/* design/ibim_timebase.sv */
`timescale 1ns / 1ps

module ibim_timebase #(
    parameter int COUNT_WIDTH = ibim_pkg::COUNT_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ibim_pkg::ibim_ctrl_t    ctrl,
    input  ibim_pkg::ibim_cfg_t     cfg,
    input  logic [COUNT_WIDTH-1:0]  now_count,
    input  logic [COUNT_WIDTH-1:0]  prev_count,
    output ibim_pkg::ibim_status_t  status
);
    import ibim_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > WIN_W) ? COUNT_WIDTH : WIN_W;

    logic [7:0]             sub_ms_reg, sub_ms_next, sub_inc;
    logic [9:0]             ms_count_reg, ms_count_next, ms_inc;
    logic                   pending_reg, pending_next;
    logic [7:0]             detect_timer_reg, detect_timer_next;
    logic [7:0]             alarm_timer_reg, alarm_timer_next;
    logic [HOLDOFF_W-1:0]   holdoff_reg, holdoff_next;
    logic                   detect_reg, detect_next;
    logic                   alarm_reg, alarm_next;
    logic                   fault_reg, fault_next;
    logic [COUNT_WIDTH-1:0] min_reg, min_next;
    logic [COUNT_WIDTH-1:0] max_reg, max_next;

    logic [CMP_W-1:0] low_x, high_x, now_x, min_x, max_x;
    logic             bad, ms_tick, wrap, holdoff_zero, serve;

    assign low_x  = CMP_W'(cfg.window_low);
    assign high_x = CMP_W'(cfg.window_high);
    assign now_x  = CMP_W'(now_count);
    assign min_x  = CMP_W'(min_reg);
    assign max_x  = CMP_W'(max_reg);

    assign bad = ctrl.edge_hit && ((now_x > high_x) || (now_x < low_x));

    assign sub_inc      = sub_ms_reg + 8'd1;
    assign ms_tick      = ctrl.tick && (sub_inc >= cfg.ticks_per_ms);
    assign ms_inc       = ms_count_reg + 10'd1;
    assign wrap         = ms_inc >= cfg.ms_per_check;
    assign holdoff_zero = holdoff_reg == '0;
    // A check request raised on this very step is served at once if the holdoff is over.
    assign serve        = ms_tick && holdoff_zero && (pending_reg || wrap);

    always_comb
    begin
        sub_ms_next       = sub_ms_reg;
        ms_count_next     = ms_count_reg;
        pending_next      = pending_reg;
        holdoff_next      = holdoff_reg;
        detect_timer_next = detect_timer_reg;
        alarm_timer_next  = alarm_timer_reg;
        detect_next       = detect_reg;
        alarm_next        = alarm_reg;
        fault_next        = fault_reg;
        min_next          = min_reg;
        max_next          = max_reg;

        if (ctrl.tick)
        begin
            sub_ms_next = ms_tick ? 8'd0 : sub_inc;
        end

        if (ms_tick)
        begin
            ms_count_next = wrap ? 10'd0 : ms_inc;
            if (detect_timer_reg != 8'd0)
            begin
                detect_timer_next = detect_timer_reg - 8'd1;
                if (detect_timer_reg == 8'd1)
                begin
                    detect_next = 1'b0;
                end
            end
            if (alarm_timer_reg != 8'd0)
            begin
                alarm_timer_next = alarm_timer_reg - 8'd1;
                if (alarm_timer_reg == 8'd1)
                begin
                    alarm_next = 1'b0;
                end
            end
            if (!holdoff_zero)
            begin
                holdoff_next = holdoff_reg - HOLDOFF_W'(1);
                pending_next = pending_reg || wrap;
            end
            else
            begin
                pending_next = 1'b0;
            end
        end

        if (serve)
        begin
            fault_next = (min_x < low_x) || (max_x > high_x);
            min_next   = '1;
            max_next   = '0;
        end

        // A zero duration leaves the level set with its timer idle.
        if (bad)
        begin
            detect_next       = 1'b1;
            detect_timer_next = cfg.detect_pulse_ms;
            alarm_next        = 1'b1;
            alarm_timer_next  = cfg.alarm_ms;
        end

        // The previously stored interval, not the fresh one, feeds the window extremes.
        if (ctrl.edge_hit && holdoff_zero)
        begin
            if (prev_count < min_reg)
            begin
                min_next = prev_count;
            end
            if (prev_count > max_reg)
            begin
                max_next = prev_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_ms_reg       <= '0;
            ms_count_reg     <= '0;
            pending_reg      <= 1'b0;
            holdoff_reg      <= HOLDOFF_RESET;
            detect_timer_reg <= '0;
            alarm_timer_reg  <= '0;
            detect_reg       <= 1'b0;
            alarm_reg        <= 1'b0;
            fault_reg        <= 1'b0;
            min_reg          <= '1;
            max_reg          <= '0;
        end
        else
        begin
            sub_ms_reg       <= sub_ms_next;
            ms_count_reg     <= ms_count_next;
            pending_reg      <= pending_next;
            holdoff_reg      <= holdoff_next;
            detect_timer_reg <= detect_timer_next;
            alarm_timer_reg  <= alarm_timer_next;
            detect_reg       <= detect_next;
            alarm_reg        <= alarm_next;
            fault_reg        <= fault_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
        end
    end

    assign status.detect = detect_next;
    assign status.alarm  = alarm_next;
    assign status.fault  = fault_next;
    assign status.bad    = bad;

endmodule

/* design/ir_beam_interval_monitor_unit.sv */
// Flow: a word accepted into the input register moves on into the result register as soon
// as that register is free, and it stays offered on the outputs until out_stall is low.
// Throughput: one word per cycle unless stalled; an input and a result register bracket a
// single pass through the channel counters and the shared timer and window logic.
// in_stall rises only when the input register is full and a stalled result blocks it.
// Reset (rst_n low, asynchronous) clears counters, timers and levels, sets the window
// minimum to all ones, reloads the holdoff timer and restores the register defaults.
`timescale 1ns / 1ps

module ir_beam_interval_monitor_unit #(
    parameter int NUM_CHANNELS = ibim_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = ibim_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [ibim_pkg::CHAN_W-1:0]       channel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              detect_out,
    output logic                              alarm_on,
    output logic                              fault_lamp,
    output logic                              bad_interval,
    input  logic                              cfg_write,
    input  ibim_pkg::cfg_idx_t                cfg_index,
    input  logic [ibim_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ibim_pkg::*;

    ibim_cfg_t    cfg_reg;
    logic         s1_valid_reg;
    logic         kind_reg;
    logic [CHAN_W-1:0] channel_reg;
    logic         out_valid_reg;
    ibim_status_t result_reg;

    logic         out_free, process, accept;
    logic         tick_strobe, edge_strobe;
    ibim_ctrl_t   ctrl;
    ibim_status_t status;

    logic [NUM_CHANNELS-1:0] hit;
    logic [COUNT_WIDTH-1:0]  count [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  last  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  now_sel, prev_sel;

    // The result register frees up when it is empty or its word leaves this cycle.
    assign out_free    = !out_valid_reg || !out_stall;
    assign process     = s1_valid_reg && out_free;
    assign in_stall    = s1_valid_reg && !out_free;
    assign accept      = in_valid && !in_stall;

    assign tick_strobe = process && !kind_reg;
    // Edges on channels that do not exist change nothing.
    assign edge_strobe = process && kind_reg && (int'(channel_reg) < NUM_CHANNELS);

    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_lane
        assign hit[c] = edge_strobe && (int'(channel_reg) == c);

        ibim_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .tick  (tick_strobe),
            .clear (hit[c]),
            .count (count[c]),
            .last  (last[c])
        );
    end

    always_comb
    begin
        now_sel  = '0;
        prev_sel = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            now_sel  = now_sel  | (count[c] & {COUNT_WIDTH{hit[c]}});
            prev_sel = prev_sel | (last[c]  & {COUNT_WIDTH{hit[c]}});
        end
    end

    assign ctrl.tick     = tick_strobe;
    assign ctrl.edge_hit = edge_strobe;

    ibim_timebase #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timebase (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .now_count  (now_sel),
        .prev_count (prev_sel),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WINDOW_LOW:      cfg_reg.window_low      <= cfg_data;
                CFG_WINDOW_HIGH:     cfg_reg.window_high     <= cfg_data;
                CFG_TICKS_PER_MS:    cfg_reg.ticks_per_ms    <= cfg_data[7:0];
                CFG_MS_PER_CHECK:    cfg_reg.ms_per_check    <= cfg_data[9:0];
                CFG_DETECT_PULSE_MS: cfg_reg.detect_pulse_ms <= cfg_data[7:0];
                CFG_ALARM_MS:        cfg_reg.alarm_ms        <= cfg_data[7:0];
                // The holdoff length only counts from reset, which reloads the default.
                CFG_HOLDOFF_MS:      cfg_reg <= cfg_reg;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (process)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            channel_reg <= channel;
        end
        if (process)
        begin
            result_reg <= status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign detect_out   = result_reg.detect;
    assign alarm_on     = result_reg.alarm;
    assign fault_lamp   = result_reg.fault;
    assign bad_interval = result_reg.bad;

endmodule

/* design/ibim_checker.sv */
`timescale 1ns / 1ps
`include "ir_beam_interval_monitor_unit_assert.svh"

module ibim_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic detect_out,
    input logic alarm_on,
    input logic fault_lamp,
    input logic bad_interval
);

    // A result word waiting on a stall stays offered.
    `IBIM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result word keeps its levels.
    `IBIM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable({detect_out, alarm_on, fault_lamp, bad_interval}))

    // A bad interval always raises both the detect line and the alarm in its own word.
    `IBIM_ASSERT_NOW(a_bad_fires, clk, rst_n, out_valid && bad_interval, detect_out && alarm_on)

    // An accepted word reaches the output when out_stall is low while it waits in the input register.
    `IBIM_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && !in_stall ##1 !out_stall, out_valid)

    // An empty result register never stalls the input side.
    `IBIM_ASSERT_NOW(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

endmodule

bind ir_beam_interval_monitor_unit ibim_checker u_ibim_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .detect_out   (detect_out),
    .alarm_on     (alarm_on),
    .fault_lamp   (fault_lamp),
    .bad_interval (bad_interval)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ibim_pkg::*;

    localparam int NCH = NUM_CHANNELS_DEF;
    localparam int CW  = COUNT_WIDTH_DEF;
    localparam logic [CW-1:0] COUNT_TOP = '1;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  kind         = 1'b0;
    logic [CHAN_W-1:0]     channel      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic                  detect_out;
    logic                  alarm_on;
    logic                  fault_lamp;
    logic                  bad_interval;
    logic                  cfg_write    = 1'b0;
    cfg_idx_t              cfg_index    = CFG_WINDOW_LOW;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    typedef struct packed {
        logic              is_edge;
        logic [CHAN_W-1:0] chan;
    } beam_word_t;

    beam_word_t   pending_words[$];
    ibim_status_t expected_levels[$];
    beam_word_t   cur_word;
    ibim_status_t got_levels;
    ibim_status_t want_levels;

    int words_queued   = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int bad_seen       = 0;
    int fault_seen     = 0;
    int mismatches     = 0;
    int settings_used  = 1;
    int in_gap         = 0;
    int stall_left     = 0;
    int quiet_left [2];

    // Local copy of the monitor: per-channel counters, window tracking and timers.
    logic [CW-1:0] beam_count [NCH];
    logic [CW-1:0] interval_seen [NCH];
    logic [CW-1:0] win_min;
    logic [CW-1:0] win_max;
    logic [7:0]    sub_ms;
    logic [9:0]    ms_count;
    logic          check_due;
    logic [7:0]    det_timer;
    logic [7:0]    alm_timer;
    logic [15:0]   hold_timer;
    logic          det_lvl;
    logic          alm_lvl;
    logic          fault_lvl;

    logic [15:0]   window_low_r;
    logic [15:0]   window_high_r;
    logic [7:0]    ticks_per_ms_r;
    logic [9:0]    ms_per_check_r;
    logic [7:0]    detect_ms_r;
    logic [7:0]    alarm_ms_r;

    ir_beam_interval_monitor_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .channel      (channel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .detect_out   (detect_out),
        .alarm_on     (alarm_on),
        .fault_lamp   (fault_lamp),
        .bad_interval (bad_interval),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic ibim_status_t predict_levels(input beam_word_t w);
        ibim_status_t  lv;
        logic [CW-1:0] now;
        logic [CW-1:0] prev;
        lv = '0;
        if (!w.is_edge)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                if (beam_count[c] != COUNT_TOP)
                    beam_count[c] = beam_count[c] + CW'(1);
            end
            sub_ms = sub_ms + 8'd1;
            if (sub_ms >= ticks_per_ms_r)
            begin
                sub_ms   = '0;
                ms_count = ms_count + 10'd1;
                if (ms_count >= ms_per_check_r)
                begin
                    ms_count  = '0;
                    check_due = 1'b1;
                end
                if (det_timer != 8'd0)
                begin
                    det_timer = det_timer - 8'd1;
                    if (det_timer == 8'd0)
                        det_lvl = 1'b0;
                end
                if (alm_timer != 8'd0)
                begin
                    alm_timer = alm_timer - 8'd1;
                    if (alm_timer == 8'd0)
                        alm_lvl = 1'b0;
                end
                // A check requested during the holdoff waits for the first step after it.
                if (hold_timer != 16'd0)
                    hold_timer = hold_timer - 16'd1;
                else if (check_due)
                begin
                    check_due = 1'b0;
                    fault_lvl = (win_min < window_low_r) || (win_max > window_high_r);
                    win_min   = COUNT_TOP;
                    win_max   = '0;
                end
            end
        end
        else if (int'(w.chan) < NCH)
        begin
            now    = beam_count[w.chan];
            lv.bad = (now > window_high_r) || (now < window_low_r);
            if (lv.bad)
            begin
                det_lvl   = 1'b1;
                det_timer = detect_ms_r;
                alm_lvl   = 1'b1;
                alm_timer = alarm_ms_r;
            end
            // The window tracks the interval stored by the previous edge, not this one.
            prev                  = interval_seen[w.chan];
            interval_seen[w.chan] = now;
            beam_count[w.chan]    = '0;
            if (hold_timer == 16'd0)
            begin
                if (prev < win_min)
                    win_min = prev;
                if (prev > win_max)
                    win_max = prev;
            end
        end
        lv.detect = det_lvl;
        lv.alarm  = alm_lvl;
        lv.fault  = fault_lvl;
        return lv;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one, with calm stretches.
    function automatic int idle_len(input int side);
        int r;
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2)
        begin
            quiet_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 140)
            return 0;
        if (r < 190)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_levels.push_back(predict_levels(cur_word));
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    kind     <= cur_word.is_edge;
                    channel  <= cur_word.chan;
                    in_gap   = idle_len(0);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got_levels = {detect_out, alarm_on, fault_lamp, bad_interval};
                if (expected_levels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing expected: det %b alm %b flt %b bad %b",
                                 $realtime, got_levels.detect, got_levels.alarm,
                                 got_levels.fault, got_levels.bad);
                end
                else
                begin
                    want_levels = expected_levels.pop_front();
                    if (want_levels.bad)
                        bad_seen++;
                    if (want_levels.fault)
                        fault_seen++;
                    if (got_levels.detect !== want_levels.detect ||
                        got_levels.alarm  !== want_levels.alarm  ||
                        got_levels.fault  !== want_levels.fault  ||
                        got_levels.bad    !== want_levels.bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d det %b/%b alm %b/%b flt %b/%b bad %b/%b (exp/got)",
                                     $realtime, results_seen,
                                     want_levels.detect, got_levels.detect,
                                     want_levels.alarm, got_levels.alarm,
                                     want_levels.fault, got_levels.fault,
                                     want_levels.bad, got_levels.bad);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = idle_len(1);
            end
        end
    end

    task automatic queue_word(input logic is_edge, input int chan);
        beam_word_t w;
        w.is_edge = is_edge;
        w.chan    = chan[CHAN_W-1:0];
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_word(1'b0, 0);
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_WINDOW_LOW:      window_low_r   = value;
            CFG_WINDOW_HIGH:     window_high_r  = value;
            CFG_TICKS_PER_MS:    ticks_per_ms_r = value[7:0];
            CFG_MS_PER_CHECK:    ms_per_check_r = value[9:0];
            CFG_DETECT_PULSE_MS: detect_ms_r    = value[7:0];
            CFG_ALARM_MS:        alarm_ms_r     = value[7:0];
            // The holdoff length is only loaded at reset, so a write changes nothing here.
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int lo, input int hi, input int tpm, input int mpc,
                                  input int det, input int alm);
        write_reg(CFG_WINDOW_LOW, lo[15:0]);
        write_reg(CFG_WINDOW_HIGH, hi[15:0]);
        write_reg(CFG_TICKS_PER_MS, tpm[15:0]);
        write_reg(CFG_MS_PER_CHECK, mpc[15:0]);
        write_reg(CFG_DETECT_PULSE_MS, det[15:0]);
        write_reg(CFG_ALARM_MS, alm[15:0]);
        settings_used++;
    endtask

    // Mostly runs of ticks closed by an edge, so intervals land near the window,
    // with bursts of edges on one channel and arbitrary words as noise.
    task automatic queue_random(input int n);
        int made;
        int k;
        int ch;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
                queue_ticks(k);
                queue_word(1'b1, $urandom_range(0, NCH - 1));
                made += k + 1;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                k  = $urandom_range(2, 4);
                ch = $urandom_range(0, NCH - 1);
                repeat (k) queue_word(1'b1, ch);
                made += k;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k) queue_word(1'($urandom_range(0, 1)), int'($urandom_range(0, 7)));
                made += k;
            end
        end
    endtask

    initial
    begin
        int lo;
        for (int c = 0; c < NCH; c++)
        begin
            beam_count[c]    = '0;
            interval_seen[c] = '0;
        end
        win_min        = COUNT_TOP;
        win_max        = '0;
        sub_ms         = '0;
        ms_count       = '0;
        check_due      = 1'b0;
        det_timer      = '0;
        alm_timer      = '0;
        hold_timer     = HOLDOFF_RESET;
        det_lvl        = 1'b0;
        alm_lvl        = 1'b0;
        fault_lvl      = 1'b0;
        window_low_r   = CFG_RESET.window_low;
        window_high_r  = CFG_RESET.window_high;
        ticks_per_ms_r = CFG_RESET.ticks_per_ms;
        ms_per_check_r = CFG_RESET.ms_per_check;
        detect_ms_r    = CFG_RESET.detect_pulse_ms;
        alarm_ms_r     = CFG_RESET.alarm_ms;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults while the power-on holdoff runs: early, good and late edges.
        queue_word(1'b1, 0);
        queue_ticks(24);
        queue_word(1'b1, 0);
        queue_word(1'b1, 7);
        queue_word(1'b1, 3);
        queue_ticks(6);
        queue_word(1'b1, 3);
        queue_word(1'b1, 7);
        queue_word(1'b1, 5);
        wait_idle();

        // Zero durations leave detect and alarm stuck on; a tick per millisecond and a
        // check request on every step, all held back until the holdoff runs out.
        apply_settings(5, 5, 0, 0, 0, 0);
        write_reg(CFG_HOLDOFF_MS, 16'hFFFF);
        queue_ticks(5);
        queue_word(1'b1, 6);
        queue_ticks(5);
        queue_word(1'b1, 6);
        queue_ticks(420);
        queue_word(1'b1, 1);
        queue_word(1'b1, 2);
        wait_idle();

        apply_settings(20, 40, 1, 3, 2, 6);
        queue_random(80);
        wait_idle();

        write_reg(CFG_HOLDOFF_MS, 16'h0000);
        apply_settings(0, 65535, 3, 1023, 255, 255);
        queue_random(80);
        wait_idle();

        apply_settings(65535, 0, 2, 1, 1, 1);
        queue_random(80);
        wait_idle();

        repeat (3)
        begin
            lo = $urandom_range(8, 30);
            apply_settings(lo, lo + $urandom_range(0, 25), $urandom_range(0, 4),
                           $urandom_range(0, 25), $urandom_range(0, 12),
                           $urandom_range(1, 40));
            queue_random(80);
            wait_idle();
        end

        // Slow millisecond steps with a check on every step and a window from 0 up to 65534.
        apply_settings(0, 65534, 255, 1, 3, 3);
        queue_random(80);
        wait_idle();

        repeat (20) @(posedge clk);
        if (expected_levels.size() != 0)
            mismatches++;
        $display("Run covered %0d words of ticks and edges over %0d register settings.",
                 words_accepted, settings_used);
        $display("%0d results checked: %0d bad intervals, %0d with the fault lamp lit, %0d mismatches.",
                 results_seen, bad_seen, fault_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
